// ===== rtl/core/dfva_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dfva_pkg;

  localparam int unsigned MaxScenesDefault = 16;

  localparam int unsigned OpW     = 2;
  localparam int unsigned SceneW  = 4;
  localparam int unsigned FreqW   = 16;
  localparam int unsigned VotesW  = 8;
  localparam int unsigned KindW   = 2;
  localparam int unsigned CfgW    = 5;

  localparam logic [FreqW-1:0]  ForceTopMark = 16'hbacd;
  localparam logic [VotesW-1:0] VoteLimit    = 8'hff;

  localparam logic [OpW-1:0] OpVote    = 2'd0;
  localparam logic [OpW-1:0] OpUnvote  = 2'd1;
  localparam logic [OpW-1:0] OpSetFreq = 2'd2;
  localparam logic [OpW-1:0] OpRead    = 2'd3;

  localparam logic StatusOk     = 1'b0;
  localparam logic StatusBadIdx = 1'b1;

  localparam logic [KindW-1:0] ReqNone     = 2'd0;
  localparam logic [KindW-1:0] ReqSend     = 2'd1;
  localparam logic [KindW-1:0] ReqForceTop = 2'd2;
  localparam logic [KindW-1:0] ReqAutoSend = 2'd3;

  typedef struct packed {
    logic latch_cmd;
    logic rd_cmd_idx;
    logic res_invalid;
    logic modify;
    logic scan_clr;
    logic scan_issue;
    logic set_request;
    logic out_load;
  } dfva_cmd_t;

  typedef struct packed {
    logic idx_ok;
    logic is_read;
    logic scan_done;
    logic out_free;
  } dfva_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/dfva_cmd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface dfva_cmd_if
  import dfva_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    op;
  logic [SceneW-1:0] scene_index;
  logic [FreqW-1:0]  new_freq;

  modport source (output valid, output op, output scene_index, output new_freq, input ready);
  modport sink (input valid, input op, input scene_index, input new_freq, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dfva_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface dfva_res_if
  import dfva_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              status;
  logic [KindW-1:0]  request_kind;
  logic [FreqW-1:0]  request_freq;
  logic [FreqW-1:0]  read_freq;
  logic [VotesW-1:0] read_votes;

  modport source (
    output valid, output status, output request_kind, output request_freq,
    output read_freq, output read_votes, input ready
  );
  modport sink (
    input valid, input status, input request_kind, input request_freq,
    input read_freq, input read_votes, output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/dfva_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dfva_ctrl
  import dfva_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire dfva_sts_t sts_i,
  output dfva_cmd_t      cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StChk  = 3'd1;
  localparam logic [2:0] StMod  = 3'd2;
  localparam logic [2:0] StScan = 3'd3;
  localparam logic [2:0] StReq  = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_cmd = 1'b1;
          state_d         = StChk;
        end
      end
      StChk: begin
        cmd_o.rd_cmd_idx = 1'b1;
        if (sts_i.idx_ok) begin
          state_d = StMod;
        end else begin
          cmd_o.res_invalid = 1'b1;
          state_d           = StDone;
        end
      end
      StMod: begin
        cmd_o.modify = 1'b1;
        if (sts_i.is_read) begin
          state_d = StDone;
        end else begin
          cmd_o.scan_clr = 1'b1;
          state_d        = StScan;
        end
      end
      StScan: begin
        if (!sts_i.scan_done) begin
          cmd_o.scan_issue = 1'b1;
        end else begin
          state_d = StReq;
        end
      end
      StReq: begin
        cmd_o.set_request = 1'b1;
        state_d           = StDone;
      end
      StDone: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dfva_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dfva_dp
  import dfva_pkg::*;
#(
  parameter int unsigned MAX_SCENES = MaxScenesDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  dfva_cmd_if.sink             cmd_i,
  dfva_res_if.source           res_o,
  input  wire dfva_cmd_t       cmd_ctl_i,
  output dfva_sts_t            sts_o
);

  localparam int unsigned IdxW = (MAX_SCENES > 1) ? $clog2(MAX_SCENES) : 1;
  localparam int unsigned CntW = $clog2(MAX_SCENES + 1);

  logic [CfgW-1:0]   active_q;
  logic [CntW-1:0]   eff_n;
  logic [OpW-1:0]    op_q;
  logic [SceneW-1:0] idx_q;
  logic [FreqW-1:0]  nf_q;

  logic [FreqW-1:0]  freq_mem [MAX_SCENES];
  logic [VotesW-1:0] votes_mem [MAX_SCENES];
  logic [MAX_SCENES-1:0] entry_vld_q;

  logic [IdxW-1:0]   cmd_addr;
  logic [IdxW-1:0]   rd_addr;
  logic [FreqW-1:0]  rd_freq_q;
  logic [VotesW-1:0] rd_votes_q;
  logic              rd_vld_q;
  logic [FreqW-1:0]  cur_freq;
  logic [VotesW-1:0] cur_votes;

  logic              we;
  logic [FreqW-1:0]  wr_freq;
  logic [VotesW-1:0] wr_votes;

  logic [CntW-1:0]   cnt_q;
  logic              scan_pend_q;
  logic [FreqW-1:0]  best_q;
  logic [FreqW-1:0]  last_q;

  logic              res_status_q;
  logic [KindW-1:0]  res_kind_q;
  logic [FreqW-1:0]  res_freq_q;
  logic [FreqW-1:0]  res_rfreq_q;
  logic [VotesW-1:0] res_rvotes_q;

  logic              out_valid_q;
  logic              out_status_q;
  logic [KindW-1:0]  out_kind_q;
  logic [FreqW-1:0]  out_freq_q;
  logic [FreqW-1:0]  out_rfreq_q;
  logic [VotesW-1:0] out_rvotes_q;

  logic [KindW-1:0]  new_kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  assign eff_n = (32'(active_q) > MAX_SCENES) ? CntW'(MAX_SCENES) : CntW'(active_q);

  always_ff @(posedge clk_i) begin
    if (cmd_ctl_i.latch_cmd) begin
      op_q  <= cmd_i.op;
      idx_q <= cmd_i.scene_index;
      nf_q  <= cmd_i.new_freq;
    end
  end

  assign cmd_addr = IdxW'(idx_q);
  assign rd_addr  = cmd_ctl_i.rd_cmd_idx ? cmd_addr : cnt_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    rd_freq_q  <= freq_mem[rd_addr];
    rd_votes_q <= votes_mem[rd_addr];
    if (we) begin
      freq_mem[cmd_addr]  <= wr_freq;
      votes_mem[cmd_addr] <= wr_votes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      rd_vld_q <= entry_vld_q[rd_addr];
      if (we) begin
        entry_vld_q[cmd_addr] <= 1'b1;
      end
    end
  end

  assign cur_freq  = rd_vld_q ? rd_freq_q : '0;
  assign cur_votes = rd_vld_q ? rd_votes_q : '0;

  always_comb begin
    we       = 1'b0;
    wr_freq  = cur_freq;
    wr_votes = cur_votes;
    unique case (op_q)
      OpVote: begin
        we = cmd_ctl_i.modify;
        if (cur_votes != VoteLimit) begin
          wr_votes = cur_votes + VotesW'(1);
        end
      end
      OpUnvote: begin
        we = cmd_ctl_i.modify;
        if (cur_votes != '0) begin
          wr_votes = cur_votes - VotesW'(1);
        end
      end
      OpSetFreq: begin
        we      = cmd_ctl_i.modify;
        wr_freq = nf_q;
      end
      OpRead: begin
        we = 1'b0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      scan_pend_q <= 1'b0;
      best_q      <= '0;
      last_q      <= '0;
    end else begin
      scan_pend_q <= cmd_ctl_i.scan_issue;
      if (cmd_ctl_i.scan_clr) begin
        cnt_q <= '0;
      end else if (cmd_ctl_i.scan_issue) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_ctl_i.scan_clr) begin
        best_q <= '0;
      end else if (scan_pend_q && (cur_votes != '0) && (cur_freq > best_q)) begin
        best_q <= cur_freq;
      end
      if (cmd_ctl_i.set_request) begin
        last_q <= best_q;
      end
    end
  end

  always_comb begin
    if (best_q == last_q) begin
      new_kind = ReqNone;
    end else if (best_q == ForceTopMark) begin
      new_kind = ReqForceTop;
    end else if (last_q == ForceTopMark) begin
      new_kind = ReqAutoSend;
    end else begin
      new_kind = ReqSend;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_ctl_i.res_invalid) begin
      res_status_q <= StatusBadIdx;
      res_kind_q   <= ReqNone;
      res_freq_q   <= '0;
      res_rfreq_q  <= '0;
      res_rvotes_q <= '0;
    end else if (cmd_ctl_i.modify) begin
      res_status_q <= StatusOk;
      res_kind_q   <= ReqNone;
      res_freq_q   <= '0;
      res_rfreq_q  <= (op_q == OpRead) ? cur_freq : '0;
      res_rvotes_q <= (op_q == OpRead) ? cur_votes : '0;
    end else if (cmd_ctl_i.set_request) begin
      res_kind_q <= new_kind;
      res_freq_q <= (new_kind == ReqNone) ? '0 : best_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_ctl_i.out_load) begin
      out_status_q <= res_status_q;
      out_kind_q   <= res_kind_q;
      out_freq_q   <= res_freq_q;
      out_rfreq_q  <= res_rfreq_q;
      out_rvotes_q <= res_rvotes_q;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.status       = out_status_q;
  assign res_o.request_kind = out_kind_q;
  assign res_o.request_freq = out_freq_q;
  assign res_o.read_freq    = out_rfreq_q;
  assign res_o.read_votes   = out_rvotes_q;

  assign sts_o.idx_ok    = 32'(idx_q) < 32'(eff_n);
  assign sts_o.is_read   = (op_q == OpRead);
  assign sts_o.scan_done = (cnt_q == eff_n);
  assign sts_o.out_free  = !out_valid_q || res_o.ready;

endmodule

`default_nettype wire

// ===== rtl/core/ddr_freq_vote_aggregator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Keeps a table of scenes, each with a frequency and a saturating vote count, and answers every
// command beat with exactly one result beat. A vote, unvote or set frequency command rescans the
// first N active entries (N is the active_scenes register clipped to MAX_SCENES) and reports a
// request only when the highest voted frequency changes. Commands are taken one at a time; a
// table change also scans the N entries, one entry per cycle through the single read port of the
// scene table. A new command is accepted while the previous result still waits in the output
// register. The table resets to all zero at once through per-entry valid bits. Write
// active_scenes only while no command is in flight.
module ddr_freq_vote_aggregator
  import dfva_pkg::*;
#(
  parameter int unsigned MAX_SCENES = MaxScenesDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  dfva_cmd_if.sink             cmd_i,
  dfva_res_if.source           res_o
);

  dfva_cmd_t cmd_ctl;
  dfva_sts_t sts;
  logic      in_ready;

  assign cmd_i.ready = in_ready;

  dfva_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd_ctl)
  );

  dfva_dp #(
    .MAX_SCENES (MAX_SCENES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_i),
    .res_o       (res_o),
    .cmd_ctl_i   (cmd_ctl),
    .sts_o       (sts)
  );

`ifndef SYNTH
  a_bad_idx_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status == StatusBadIdx) |->
      (res_o.request_kind == ReqNone && res_o.read_freq == '0 && res_o.read_votes == '0))
    else $error("Invalid index beat carries data.");

  a_force_top_freq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.request_kind == ReqForceTop) |-> (res_o.request_freq == ForceTopMark))
    else $error("Force top request without the force mark.");

  a_no_req_no_freq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.request_kind == ReqNone) |-> (res_o.request_freq == '0))
    else $error("Request frequency set without a request.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> !cmd_i.ready)
    else $error("Command accepted while another is in progress.");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import dfva_pkg::*;

  typedef struct packed {
    logic              status;
    logic [KindW-1:0]  kind;
    logic [FreqW-1:0]  req_freq;
    logic [FreqW-1:0]  rd_freq;
    logic [VotesW-1:0] rd_votes;
  } res_t;

  typedef struct {
    bit                is_cfg;
    logic [CfgW-1:0]   cfg_val;
    logic [OpW-1:0]    op;
    logic [SceneW-1:0] idx;
    logic [FreqW-1:0]  nf;
    bit                typed;
    res_t              want;
  } step_t;

  localparam int unsigned CycleLimit = 200000;
  localparam res_t BadRes  = '{StatusBadIdx, ReqNone, 16'h0, 16'h0, 8'h0};
  localparam res_t QuietOk = '{StatusOk, ReqNone, 16'h0, 16'h0, 8'h0};

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;

  dfva_cmd_if cmd_bus ();
  dfva_res_if res_bus ();

  ddr_freq_vote_aggregator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_bus),
    .res_o       (res_bus)
  );

  logic [FreqW-1:0]  freq_table [MaxScenesDefault];
  logic [VotesW-1:0] vote_table [MaxScenesDefault];
  logic [FreqW-1:0]  last_target;
  int unsigned       scene_limit;

  res_t        pending_results [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_off = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned src_gap_pct = 0;

  step_t directed_steps [25] = '{
    '{1'b0, 5'd0,  OpRead,    4'd0,  16'h0000, 1'b1, BadRes},
    '{1'b0, 5'd0,  OpVote,    4'd15, 16'hffff, 1'b1, BadRes},
    '{1'b0, 5'd0,  OpSetFreq, 4'd0,  16'h1234, 1'b1, BadRes},
    '{1'b1, 5'd31, OpVote,    4'd0,  16'h0000, 1'b0, QuietOk},
    '{1'b0, 5'd0,  OpRead,    4'd15, 16'h0000, 1'b1, QuietOk},
    '{1'b0, 5'd0,  OpSetFreq, 4'd0,  16'hffff, 1'b1, QuietOk},
    '{1'b0, 5'd0,  OpVote,    4'd0,  16'h0000, 1'b1,
      '{StatusOk, ReqSend, 16'hffff, 16'h0, 8'h0}},
    '{1'b0, 5'd0,  OpRead,    4'd0,  16'h0000, 1'b1,
      '{StatusOk, ReqNone, 16'h0, 16'hffff, 8'h1}},
    '{1'b0, 5'd0,  OpUnvote,  4'd0,  16'h0000, 1'b0, QuietOk},
    '{1'b0, 5'd0,  OpUnvote,  4'd0,  16'h0000, 1'b0, QuietOk},
    '{1'b0, 5'd0,  OpSetFreq, 4'd15, 16'hbacd, 1'b0, QuietOk},
    '{1'b0, 5'd0,  OpVote,    4'd15, 16'h0000, 1'b0, QuietOk},
    '{1'b0, 5'd0,  OpSetFreq, 4'd3,  16'hbace, 1'b0, QuietOk},
    '{1'b0, 5'd0,  OpVote,    4'd3,  16'h0000, 1'b0, QuietOk},
    '{1'b0, 5'd0,  OpUnvote,  4'd3,  16'h0000, 1'b0, QuietOk},
    '{1'b0, 5'd0,  OpSetFreq, 4'd15, 16'h0001, 1'b0, QuietOk},
    '{1'b0, 5'd0,  OpVote,    4'd3,  16'h0000, 1'b0, QuietOk},
    '{1'b1, 5'd1,  OpVote,    4'd0,  16'h0000, 1'b0, QuietOk},
    '{1'b0, 5'd0,  OpVote,    4'd1,  16'h0000, 1'b1, BadRes},
    '{1'b0, 5'd0,  OpRead,    4'd0,  16'h0000, 1'b0, QuietOk},
    '{1'b0, 5'd0,  OpSetFreq, 4'd0,  16'h0000, 1'b0, QuietOk},
    '{1'b1, 5'd16, OpVote,    4'd0,  16'h0000, 1'b0, QuietOk},
    '{1'b0, 5'd0,  OpRead,    4'd15, 16'h0000, 1'b0, QuietOk},
    '{1'b0, 5'd0,  OpVote,    4'd15, 16'h0000, 1'b0, QuietOk},
    '{1'b0, 5'd0,  OpUnvote,  4'd3,  16'h0000, 1'b0, QuietOk}
  };

  always #10 clk_i = ~clk_i;

  function automatic res_t apply_command(input logic [OpW-1:0] op,
                                         input logic [SceneW-1:0] idx,
                                         input logic [FreqW-1:0] nf);
    res_t             r;
    logic [FreqW-1:0] top;
    r = QuietOk;
    top = '0;
    if (idx >= scene_limit) begin
      r.status = StatusBadIdx;
    end else if (op == OpRead) begin
      r.rd_freq = freq_table[idx];
      r.rd_votes = vote_table[idx];
    end else begin
      if (op == OpVote) begin
        if (vote_table[idx] != VoteLimit) vote_table[idx] = vote_table[idx] + 8'd1;
      end else if (op == OpUnvote) begin
        if (vote_table[idx] != '0) vote_table[idx] = vote_table[idx] - 8'd1;
      end else begin
        freq_table[idx] = nf;
      end
      for (int i = 0; i < scene_limit; i++) begin
        if (vote_table[i] != '0 && freq_table[i] > top) top = freq_table[i];
      end
      if (top != last_target) begin
        if (top == ForceTopMark) begin
          r.kind = ReqForceTop;
        end else if (last_target == ForceTopMark) begin
          r.kind = ReqAutoSend;
        end else begin
          r.kind = ReqSend;
        end
        r.req_freq = top;
        last_target = top;
      end
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Handshake signals are stable from the falling edge up to the rising edge that accepts the beat.
  task automatic issue_cmd(input logic [OpW-1:0] op, input logic [SceneW-1:0] idx,
                           input logic [FreqW-1:0] nf, input bit typed, input res_t want);
    res_t predicted;
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.op <= op;
    cmd_bus.scene_index <= idx;
    cmd_bus.new_freq <= nf;
    @(negedge clk_i);
    while (!cmd_bus.ready) @(negedge clk_i);
    @(posedge clk_i);
    predicted = apply_command(op, idx, nf);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic program_scenes(input logic [CfgW-1:0] value);
    cmd_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    scene_limit = (value > MaxScenesDefault) ? MaxScenesDefault : value;
  endtask

  task automatic run_random(input int count);
    logic [OpW-1:0]    op;
    logic [SceneW-1:0] idx;
    logic [FreqW-1:0]  nf;
    int unsigned       r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      op = (r < 38) ? OpVote : (r < 62) ? OpUnvote : (r < 85) ? OpSetFreq : OpRead;
      if (scene_limit == 0 || $urandom_range(0, 9) == 0) begin
        idx = SceneW'($urandom_range(0, 15));
      end else begin
        idx = SceneW'($urandom_range(0, scene_limit - 1));
      end
      r = $urandom_range(0, 99);
      if (r < 12) begin
        nf = ForceTopMark;
      end else if (r < 20) begin
        nf = '1;
      end else if (r < 26) begin
        nf = '0;
      end else if (r < 60) begin
        nf = FreqW'($urandom_range(1, 8) * 32'h1111);
      end else begin
        nf = FreqW'($urandom);
      end
      issue_cmd(op, idx, nf, 1'b0, QuietOk);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no command pending");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, res_bus.status);
        check_field("request_kind", want.kind, res_bus.request_kind);
        check_field("request_freq", want.req_freq, res_bus.request_freq);
        check_field("read_freq", want.rd_freq, res_bus.read_freq);
        check_field("read_votes", want.rd_votes, res_bus.read_votes);
      end
    end
  end

  initial begin : sink_pacing
    int unsigned stall_left;
    stall_left = 0;
    res_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off != 0) begin
        hold_off--;
        res_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < sink_stall_pct) begin
        stall_left = $urandom_range(1, 9) - 1;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    cmd_bus.valid = 1'b0;
    cmd_bus.op = OpVote;
    cmd_bus.scene_index = '0;
    cmd_bus.new_freq = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    foreach (freq_table[i]) begin
      freq_table[i] = '0;
      vote_table[i] = '0;
    end
    last_target = '0;
    scene_limit = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    sink_stall_pct = 25;
    src_gap_pct = 25;
    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg) begin
        program_scenes(directed_steps[i].cfg_val);
      end else begin
        issue_cmd(directed_steps[i].op, directed_steps[i].idx, directed_steps[i].nf,
                  directed_steps[i].typed, directed_steps[i].want);
      end
    end

    program_scenes(5'd16);
    sink_stall_pct = 20;
    src_gap_pct = 20;
    run_random(100);

    sink_stall_pct = 10;
    src_gap_pct = 0;
    issue_cmd(OpSetFreq, 4'd7, 16'h7777, 1'b0, QuietOk);
    repeat (258) issue_cmd(OpVote, 4'd7, 16'h0000, 1'b0, QuietOk);
    issue_cmd(OpRead, 4'd7, 16'h0000, 1'b0, QuietOk);

    program_scenes(5'd5);
    hold_off = 150;
    run_random(60);

    program_scenes(5'd31);
    sink_stall_pct = 30;
    src_gap_pct = 30;
    run_random(70);

    program_scenes(5'd0);
    run_random(10);

    program_scenes(5'($urandom_range(2, 15)));
    sink_stall_pct = 0;
    src_gap_pct = 40;
    run_random(50);

    program_scenes(5'd16);
    src_gap_pct = 0;
    run_random(80);

    cmd_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/dfva_pkg.sv
rtl/core/dfva_cmd_if.sv
rtl/core/dfva_res_if.sv
rtl/core/dfva_ctrl.sv
rtl/core/dfva_dp.sv
rtl/core/ddr_freq_vote_aggregator.sv
test/tb_top.sv
